>>> src/mme_pkg.sv
// Package for the matrix multiply engine: commands, queue job format, state and constants.
`default_nettype none
package mme_pkg;

  localparam int IDX_W   = 6;
  localparam int VAL_W   = 16;
  localparam int DIM_W   = 7;
  localparam int PROD_W  = 2 * VAL_W;
  localparam int SUM_W   = 38;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;
  localparam logic [SUM_W-1:0] SUM_MAX   = {SUM_W{1'b1}};

  // Input command codes
  typedef enum logic [1:0] {
    CMD_WR_A = 2'd0,
    CMD_WR_B = 2'd1,
    CMD_RD_C = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_t;

  // Work kinds passed from the front to the back
  typedef enum logic [1:0] {
    JOB_WR_A    = 2'd0,
    JOB_WR_B    = 2'd1,
    JOB_RD      = 2'd2,
    JOB_RD_ZERO = 2'd3
  } job_kind_t;

  typedef struct packed {
    job_kind_t        kind;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [VAL_W-1:0] value;
    logic [DIM_W-1:0] dim;
  } job_t;

  // Queue handshake between front and back
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_RUN  = 2'd1,
    ST_DONE = 2'd2
  } state_t;

endpackage
`default_nettype wire

>>> src/mme_front.sv
// Front end: accepts input transactions, holds the dimension register, classifies work.
`default_nettype none
module mme_front
  import mme_pkg::*;
#(
  parameter int MAX_DIM = 64
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_wr_en,
  input  wire logic [DIM_W-1:0] cfg_wr_data,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [1:0]       in_tuser,
  input  wire logic [31:0]      in_tdata,
  input  wire queue_status_t    q_status,
  output logic                  q_push,
  output job_t                  q_job
);

  logic [DIM_W-1:0] dim_r;
  logic [DIM_W-1:0] dim_eff;
  logic [IDX_W-1:0] row;
  logic [IDX_W-1:0] col;
  logic [VAL_W-1:0] value;
  cmd_t             cmd;
  logic             in_store;
  logic             out_of_dim;
  logic             keep;

  // Hold the dimension register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r <= DIM_RESET;
    end else if (cfg_wr_en) begin
      dim_r <= cfg_wr_data;
    end
  end

  // Unpack the transaction
  assign cmd   = cmd_t'(in_tuser);
  assign row   = in_tdata[IDX_W-1:0];
  assign col   = in_tdata[2*IDX_W-1:IDX_W];
  assign value = in_tdata[2*IDX_W+VAL_W-1:2*IDX_W];

  // Saturate the dimension to the store size
  assign dim_eff = (int'(dim_r) > MAX_DIM) ? DIM_W'(MAX_DIM) : dim_r;

  assign in_store   = (int'(row) < MAX_DIM) && (int'(col) < MAX_DIM);
  assign out_of_dim = ({1'b0, row} >= dim_eff) || ({1'b0, col} >= dim_eff);

  // Classify: drop unused commands and writes outside the store
  always_comb begin
    q_job.row   = row;
    q_job.col   = col;
    q_job.value = value;
    q_job.dim   = dim_eff;
    q_job.kind  = JOB_RD_ZERO;
    keep        = 1'b0;
    unique case (cmd)
      CMD_WR_A: begin
        q_job.kind = JOB_WR_A;
        keep       = in_store;
      end
      CMD_WR_B: begin
        q_job.kind = JOB_WR_B;
        keep       = in_store;
      end
      CMD_RD_C: begin
        q_job.kind = out_of_dim ? JOB_RD_ZERO : JOB_RD;
        keep       = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_tready = !q_status.full;
  assign q_push    = in_tvalid && in_tready && keep;

endmodule
`default_nettype wire

>>> src/mme_fifo.sv
// Short job queue between the front end and the compute back end.
`default_nettype none
module mme_fifo
  import mme_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  wire job_t   push_job,
  input  wire logic   pop,
  output job_t        head_job,
  output queue_status_t status
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push;
  logic             do_pop;

  assign status.full  = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign status.empty = (cnt_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head_job     = slot_r[rd_ptr_r];

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_push && !do_pop)      cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

  // Store the job payload
  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_job;
  end

endmodule
`default_nettype wire

>>> src/mme_back.sv
// Back end: matrix stores, multiply-accumulate pipeline and the result register.
`default_nettype none
module mme_back
  import mme_pkg::*;
#(
  parameter int MAX_DIM = 64
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire job_t          head_job,
  input  wire queue_status_t q_status,
  output logic               q_pop,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output logic [55:0]        out_tdata
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [VAL_W-1:0] mem_a [DEPTH];
  logic [VAL_W-1:0] mem_b [DEPTH];

  state_t state_r, state_nxt;

  logic [IDX_W-1:0] row_r, col_r;
  logic [DIM_W-1:0] dim_r;
  logic [DIM_W-1:0] k_r;
  logic [VAL_W-1:0] a_rd_r, b_rd_r;
  logic             rd_v_r, rd_last_r;
  logic             mul_v_r, mul_last_r;
  logic [PROD_W-1:0] prod_r;
  logic [SUM_W-1:0] acc_r, acc_nxt;
  logic [SUM_W:0]   acc_sum;

  logic             out_valid_r;
  logic [IDX_W-1:0] out_row_r, out_col_r;
  logic [SUM_W-1:0] out_sum_r;

  logic             out_free;
  logic             start_rd;
  logic             load_zero;
  logic             load_acc;
  logic             we_a, we_b;
  logic             issue_v, issue_last;
  logic [ADDR_W-1:0] wr_addr, a_addr, b_addr;

  assign out_free = !out_valid_r || out_tready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (!q_status.empty && head_job.kind == JOB_RD) state_nxt = ST_RUN;
      ST_RUN:  if (mul_v_r && mul_last_r) state_nxt = ST_DONE;
      ST_DONE: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    q_pop     = 1'b0;
    we_a      = 1'b0;
    we_b      = 1'b0;
    start_rd  = 1'b0;
    load_zero = 1'b0;
    load_acc  = 1'b0;
    issue_v   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_status.empty) begin
          unique case (head_job.kind)
            JOB_WR_A: begin
              we_a  = 1'b1;
              q_pop = 1'b1;
            end
            JOB_WR_B: begin
              we_b  = 1'b1;
              q_pop = 1'b1;
            end
            JOB_RD: begin
              start_rd = 1'b1;
              q_pop    = 1'b1;
            end
            JOB_RD_ZERO: begin
              load_zero = out_free;
              q_pop     = out_free;
            end
            default: q_pop = 1'b0;
          endcase
        end
      end
      ST_RUN:  issue_v  = (k_r < dim_r);
      ST_DONE: load_acc = out_free;
      default: q_pop    = 1'b0;
    endcase
  end

  assign issue_last = issue_v && (k_r == dim_r - 1'b1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Store addresses: row-major, row * MAX_DIM + col
  assign wr_addr = ADDR_W'(int'(head_job.row) * MAX_DIM + int'(head_job.col));
  assign a_addr  = ADDR_W'(int'(row_r) * MAX_DIM + int'(k_r));
  assign b_addr  = ADDR_W'(int'(k_r) * MAX_DIM + int'(col_r));

  // Matrix stores with registered read data
  always_ff @(posedge clk) begin
    if (we_a) mem_a[wr_addr] <= head_job.value;
    a_rd_r <= mem_a[a_addr];
  end

  always_ff @(posedge clk) begin
    if (we_b) mem_b[wr_addr] <= head_job.value;
    b_rd_r <= mem_b[b_addr];
  end

  // Latch the read request and step the inner index
  always_ff @(posedge clk) begin
    if (start_rd) begin
      row_r <= head_job.row;
      col_r <= head_job.col;
      dim_r <= head_job.dim;
      k_r   <= '0;
    end else if (issue_v) begin
      k_r <= k_r + 1'b1;
    end
  end

  // Pipeline valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r     <= 1'b0;
      rd_last_r  <= 1'b0;
      mul_v_r    <= 1'b0;
      mul_last_r <= 1'b0;
    end else begin
      rd_v_r     <= issue_v;
      rd_last_r  <= issue_last;
      mul_v_r    <= rd_v_r;
      mul_last_r <= rd_last_r;
    end
  end

  // Multiply, then saturating accumulate
  assign acc_sum = {1'b0, acc_r} + (SUM_W + 1)'(prod_r);
  assign acc_nxt = acc_sum[SUM_W] ? SUM_MAX : acc_sum[SUM_W-1:0];

  always_ff @(posedge clk) begin
    prod_r <= a_rd_r * b_rd_r;
    if (start_rd) begin
      acc_r <= '0;
    end else if (mul_v_r) begin
      acc_r <= acc_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_zero || load_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_zero) begin
      out_row_r <= head_job.row;
      out_col_r <= head_job.col;
      out_sum_r <= '0;
    end else if (load_acc) begin
      out_row_r <= row_r;
      out_col_r <= col_r;
      out_sum_r <= acc_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_sum_r, out_col_r, out_row_r};

endmodule
`default_nettype wire

>>> src/matrix_multiply_engine_unit.sv
// Top level of the matrix multiply engine: front end, job queue and compute back end.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------------------
//   in_     | slave     | in_tvalid/in_tready  | tuser: command; tdata: row, col, value
//   out_    | master    | out_tvalid/out_tready| tdata: out_row, out_col, product_value
//   cfg_    | write     | cfg_wr_en            | cfg_wr_data: dim_in_use
//
// Writes go into the stores from the queue head. A read of C inside the dimension runs
// one multiply-accumulate per cycle over the row of A and the column of B, through the store
// read, multiply and accumulate registers, then the result register. A read outside the
// dimension loads zero into the result register. The four-entry queue lets input transactions
// arrive while a read is computed; in_tready drops only when it fills. A stalled result holds
// in the output register and stalls the next read at its end. Reset is synchronous; the stores are not cleared.
`default_nettype none
module matrix_multiply_engine_unit
  import mme_pkg::*;
#(
  parameter int MAX_DIM = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [6:0]  cfg_wr_data,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [1:0]  in_tuser,   // [1:0] command
  input  wire logic [31:0] in_tdata,   // [5:0] row, [11:6] col, [27:12] value, zero pad
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata   // [5:0] out_row, [11:6] out_col, [49:12] product_value
);

  queue_status_t q_status;
  logic          q_push;
  logic          q_pop;
  job_t          push_job;
  job_t          head_job;

  mme_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tuser    (in_tuser),
    .in_tdata    (in_tdata),
    .q_status    (q_status),
    .q_push      (q_push),
    .q_job       (push_job)
  );

  mme_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head_job (head_job),
    .status   (q_status)
  );

  mme_back #(
    .MAX_DIM (MAX_DIM)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_job   (head_job),
    .q_status   (q_status),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire

>>> tb/sv/testbench.sv
// Self-checking testbench for the matrix multiply engine: directed and random stream traffic.
module testbench;
  import mme_pkg::*;

  localparam int MAX_DIM      = 64;
  localparam int STORE_SIZE   = MAX_DIM * MAX_DIM;
  localparam int QUIET_CYCLES = 24;
  localparam int DRAIN_CYCLES = 80;
  localparam int STALL_LIMIT  = 4000;
  localparam int REPORT_LIMIT = 10;

  typedef struct {
    logic [5:0]  row;
    logic [5:0]  col;
    logic [37:0] sum;
  } product_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [6:0]  cfg_wr_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [1:0]  in_tuser = CMD_NOP;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;

  // Shadow copy of both element stores and of the dimension register
  logic [15:0] a_image [STORE_SIZE];
  logic [15:0] b_image [STORE_SIZE];
  bit          a_written [STORE_SIZE];
  bit          b_written [STORE_SIZE];
  logic [6:0]  dim_setting = DIM_RESET;

  // Rows of A and columns of B that are written across all 64 terms
  int          full_rows [$];
  int          full_cols [$];

  product_t    pending_products [$];
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          mismatch_count = 0;
  int          items_sent = 0;
  int          reads_checked = 0;

  matrix_multiply_engine_unit #(.MAX_DIM(MAX_DIM)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),   // [1:0] command
    .in_tdata   (in_tdata),   // [5:0] row, [11:6] col, [27:12] value, zero pad
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)   // [5:0] out_row, [11:6] out_col, [49:12] product_value
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Dimension actually used: the register saturated to the store size
  function automatic int effective_span();
    return (dim_setting > MAX_DIM) ? MAX_DIM : int'(dim_setting);
  endfunction

  // Exact dot product of row r of A and column c of B, zero outside the span
  function automatic logic [37:0] dot_product_of(logic [5:0] r, logic [5:0] c);
    int          span;
    int          k;
    logic [38:0] acc;
    span = effective_span();
    acc = '0;
    if (r < span && c < span) begin
      for (k = 0; k < span; k++) begin
        acc = acc + a_image[r * MAX_DIM + k] * b_image[k * MAX_DIM + c];
        if (acc > {1'b0, SUM_MAX}) acc = {1'b0, SUM_MAX};
      end
    end
    return acc[37:0];
  endfunction

  // True when a read touches only store entries that hold written data
  function automatic bit read_is_safe(logic [5:0] r, logic [5:0] c);
    int span;
    int k;
    bit ok;
    span = effective_span();
    ok = 1'b1;
    if (r < span && c < span) begin
      for (k = 0; k < span; k++) begin
        if (!a_written[r * MAX_DIM + k] || !b_written[k * MAX_DIM + c]) ok = 1'b0;
      end
    end
    return ok;
  endfunction

  // Favor the extremes of the Q0.16 range
  function automatic logic [15:0] pick_value();
    int p;
    p = $urandom_range(99);
    if (p < 15) return 16'h0000;
    if (p < 30) return 16'hFFFF;
    return 16'($urandom_range(16'hFFFF));
  endfunction

  task automatic set_idling(input int mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
      default: begin send_idle_pct = 29; recv_stall_pct = 29; end
    endcase
  endtask

  // Send one transaction and update the shadow state once it is accepted
  task automatic send_item(input cmd_t cmd, input logic [5:0] r, input logic [5:0] c,
                           input logic [15:0] v);
    int       idx;
    product_t entry;
    idx = r * MAX_DIM + c;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {4'b0000, v, c, r};
    do @(posedge clk); while (!in_tready);
    items_sent++;
    case (cmd)
      CMD_WR_A: begin
        a_image[idx]   = v;
        a_written[idx] = 1'b1;
      end
      CMD_WR_B: begin
        b_image[idx]   = v;
        b_written[idx] = 1'b1;
      end
      CMD_RD_C: begin
        entry.row = r;
        entry.col = c;
        entry.sum = dot_product_of(r, c);
        pending_products.push_back(entry);
      end
      default: ;
    endcase
  endtask

  // Drop valid, wait for every outstanding product, then let queued writes retire
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_products.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic set_dimension(input logic [6:0] d);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= d;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    dim_setting = d;
  endtask

  // Write row r of A and column c of B over all 64 terms
  task automatic fill_cross(input int r, input int c, input bit use_max);
    int k;
    for (k = 0; k < MAX_DIM; k++) begin
      send_item(CMD_WR_A, 6'(r), 6'(k), use_max ? 16'hFFFF : pick_value());
      send_item(CMD_WR_B, 6'(k), 6'(c), use_max ? 16'hFFFF : pick_value());
    end
    full_rows.push_back(r);
    full_cols.push_back(c);
  endtask

  // Reset dimension: the largest possible sum on the full 64-term product
  task automatic test_default_dimension();
    send_item(CMD_NOP, 6'd0, 6'd0, 16'h0000);
    fill_cross(0, 0, 1'b1);
    send_item(CMD_RD_C, 6'd0, 6'd0, 16'h0000);
  endtask

  // Small product with extreme values, reads outside the span and ignored commands
  task automatic test_small_product();
    set_dimension(7'd2);
    send_item(CMD_WR_A, 6'd0, 6'd0, 16'hFFFF);
    send_item(CMD_WR_A, 6'd0, 6'd1, 16'hFFFF);
    send_item(CMD_WR_A, 6'd1, 6'd0, 16'h0000);
    send_item(CMD_WR_A, 6'd1, 6'd1, 16'h0001);
    send_item(CMD_WR_B, 6'd0, 6'd0, 16'hFFFF);
    send_item(CMD_WR_B, 6'd1, 6'd0, 16'hFFFF);
    send_item(CMD_WR_B, 6'd0, 6'd1, 16'h0001);
    send_item(CMD_WR_B, 6'd1, 6'd1, 16'h8000);
    send_item(CMD_RD_C, 6'd0, 6'd0, 16'hFFFF);
    send_item(CMD_RD_C, 6'd0, 6'd1, 16'h0000);
    send_item(CMD_RD_C, 6'd1, 6'd0, 16'h0000);
    send_item(CMD_RD_C, 6'd1, 6'd1, 16'h5A5A);
    send_item(CMD_RD_C, 6'd2, 6'd0, 16'h0000);
    send_item(CMD_RD_C, 6'd0, 6'd2, 16'h0000);
    send_item(CMD_RD_C, 6'd63, 6'd63, 16'hFFFF);
    // Store outside the span is kept
    send_item(CMD_WR_A, 6'd40, 6'd63, 16'hFFFF);
    send_item(CMD_WR_B, 6'd63, 6'd40, 16'h0001);
    // Unused command must neither write nor answer
    send_item(CMD_NOP, 6'd63, 6'd63, 16'hFFFF);
    send_item(CMD_NOP, 6'd0, 6'd0, 16'h1234);
    send_item(CMD_RD_C, 6'd0, 6'd0, 16'h0000);
  endtask

  // Dimension zero, one and values above the store size
  task automatic test_dimension_limits();
    set_dimension(7'd0);
    send_item(CMD_RD_C, 6'd0, 6'd0, 16'h0000);
    send_item(CMD_RD_C, 6'd63, 6'd63, 16'h0000);
    set_dimension(7'd1);
    send_item(CMD_RD_C, 6'd0, 6'd0, 16'h0000);
    send_item(CMD_RD_C, 6'd0, 6'd1, 16'h0000);
    send_item(CMD_RD_C, 6'd1, 6'd0, 16'h0000);
    set_dimension(7'd127);
    send_item(CMD_RD_C, 6'd0, 6'd0, 16'h0000);
  endtask

  // One dimension setting: fill what reads need, then mixed random traffic
  task automatic run_random_phase(input logic [6:0] dim, input int mode, input int count);
    int         span;
    int         i;
    int         j;
    int         p;
    int         pick;
    logic [5:0] r;
    logic [5:0] c;
    set_dimension(dim);
    set_idling(mode);
    span = effective_span();
    if (span == MAX_DIM) begin
      fill_cross($urandom_range(MAX_DIM - 1), $urandom_range(MAX_DIM - 1), 1'b0);
    end else begin
      for (i = 0; i < span; i++) begin
        for (j = 0; j < span; j++) begin
          send_item(CMD_WR_A, 6'(i), 6'(j), pick_value());
          send_item(CMD_WR_B, 6'(i), 6'(j), pick_value());
        end
      end
    end
    for (i = 0; i < count; i++) begin
      p = $urandom_range(99);
      r = 6'($urandom_range(MAX_DIM - 1));
      c = 6'($urandom_range(MAX_DIM - 1));
      if (p < 50) begin
        if (span > 0 && $urandom_range(99) < 75) begin
          r = 6'($urandom_range(span - 1));
          c = 6'($urandom_range(span - 1));
        end
        // Redirect to a fully written row and column when needed
        if (!read_is_safe(r, c)) begin
          pick = $urandom_range(full_rows.size() - 1);
          r = 6'(full_rows[pick]);
          pick = $urandom_range(full_cols.size() - 1);
          c = 6'(full_cols[pick]);
        end
        send_item(CMD_RD_C, r, c, 16'($urandom_range(16'hFFFF)));
      end else if (p < 94) begin
        if (span > 0 && $urandom_range(99) < 60) begin
          r = 6'($urandom_range(span - 1));
          c = 6'($urandom_range(span - 1));
        end
        send_item(($urandom_range(1) == 0) ? CMD_WR_A : CMD_WR_B, r, c, pick_value());
      end else begin
        send_item(CMD_NOP, r, c, 16'($urandom_range(16'hFFFF)));
      end
    end
  endtask

  task automatic test_random_traffic();
    logic [6:0] dims [12];
    int         n;
    dims = '{7'd3, 7'd64, 7'd5, 7'd0, 7'd1, 7'd7, 7'd127, 7'd2, 7'd6, 7'd100, 7'd4, 7'd8};
    for (n = 0; n < 12; n++) run_random_phase(dims[n], n % 4, 55);
  endtask

  // Randomize result back-pressure
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each accepted result with the oldest predicted product
  always @(posedge clk) begin
    product_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_products.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("unexpected result: row %0d col %0d sum %0h",
                   out_tdata[5:0], out_tdata[11:6], out_tdata[49:12]);
      end else begin
        want = pending_products.pop_front();
        reads_checked++;
        if (out_tdata[5:0] !== want.row || out_tdata[11:6] !== want.col ||
            out_tdata[49:12] !== want.sum) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display({"result differs: expected row %0d col %0d sum %0h, ",
                      "got row %0d col %0d sum %0h"},
                     want.row, want.col, want.sum,
                     out_tdata[5:0], out_tdata[11:6], out_tdata[49:12]);
        end
      end
    end
  end

  // End the run when no transaction moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
    $display("matrix_multiply_engine_unit: mismatch");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_dimension();
    test_small_product();
    test_dimension_limits();
    test_random_traffic();
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d input transactions, checked %0d product reads", items_sent, reads_checked);
    $display("dimensions 0 to 8, 64 and above, with sender and receiver idling mixes");
    if (mismatch_count == 0) begin
      $display("matrix_multiply_engine_unit: match");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("matrix_multiply_engine_unit: mismatch");
    end
    $finish;
  end

endmodule
